[rtl/core/i2c_seq_pkg.sv]
package i2c_seq_pkg;

    // Bus phases of the sequencer
    typedef enum logic [4:0] {
        ST_IDLE = 5'd0,
        ST_PREP = 5'd1,
        ST_S1   = 5'd2,
        ST_S2   = 5'd3,
        ST_S3   = 5'd4,
        ST_WLO  = 5'd5,
        ST_WHI  = 5'd6,
        ST_WLO2 = 5'd7,
        ST_A1   = 5'd8,
        ST_A2   = 5'd9,
        ST_A3   = 5'd10,
        ST_RLO  = 5'd11,
        ST_RHI  = 5'd12,
        ST_N1   = 5'd13,
        ST_N2   = 5'd14,
        ST_N3   = 5'd15,
        ST_P1   = 5'd16,
        ST_P2   = 5'd17,
        ST_P3   = 5'd18
    } seq_state_t;

    typedef enum logic [1:0] {
        REQ_NONE       = 2'd0,
        REQ_READ       = 2'd1,
        REQ_REG_WRITE  = 2'd2,
        REQ_BYTE_WRITE = 2'd3
    } req_kind_t;

    // Which byte of the transaction is on the bus
    typedef enum logic [1:0] {
        BYTE_ADDR  = 2'd0,
        BYTE_REG   = 2'd1,
        BYTE_THIRD = 2'd2
    } byte_sel_t;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       nack;
        logic       rejected;
    } result_t;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd100;
    localparam logic [7:0]  ABORT_DATA        = 8'hff;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

    function automatic logic scl_of(input seq_state_t st);
        logic r;
        case (st)
            ST_S3, ST_WLO, ST_WLO2, ST_A1, ST_A3, ST_RLO, ST_N1, ST_N3, ST_P1:
                r = 1'b1;
            default:
                r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic sda_of(input seq_state_t st);
        logic r;
        case (st)
            ST_S2, ST_S3, ST_P1, ST_P2:
                r = 1'b1;
            default:
                r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/i2c_seq_in_if.sv]
interface i2c_seq_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic       sda_in;

    modport source (output valid, req_type, dev_addr, reg_addr, wr_data, sda_in,
                    input ready);
    modport sink   (input valid, req_type, dev_addr, reg_addr, wr_data, sda_in,
                    output ready);
endinterface

[rtl/core/i2c_seq_out_if.sv]
interface i2c_seq_out_if;
    logic       valid;
    logic       ready;
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       nack;
    logic       rejected;

    modport source (output valid, scl_pull_low, sda_pull_low, busy_res, done_res,
                    read_data, nack, rejected,
                    input ready);
    modport sink   (input valid, scl_pull_low, sda_pull_low, busy_res, done_res,
                    read_data, nack, rejected,
                    output ready);
endinterface

[rtl/core/i2c_master_transaction_sequencer_top.sv]
// Channel   Dir  Words                                         Handshake
// req_ch    in   req_type, dev_addr, reg_addr, wr_data, sda_in  valid/ready
// res_ch    out  scl/sda pulls, busy, done, read_data, nack,   valid/ready
//                rejected
// cfg       in   phase_ticks (16 bit)                           cfg_we, no ready
//
// Every accepted word is one bus tick and yields exactly one result word.
// A word is taken every cycle while req_ch.ready is high; its result is registered as the word is taken.
// Results land in an output register backed by a one-word skid stage, so a
// new word is still accepted while one result waits; req_ch.ready drops
// only when both are full. Reset (rst_n low, async) returns to idle with
// phase_ticks = 100 and empty output buffers.
module i2c_master_transaction_sequencer_top #(
    parameter int PHASE_COUNT_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata,
    i2c_seq_in_if.sink           req_ch,
    i2c_seq_out_if.source        res_ch
);

    // Compare width: large enough for both the 16-bit register and the cap
    localparam int LW = ((PHASE_COUNT_BITS > 16) ? PHASE_COUNT_BITS : 16) + 1;
    localparam logic [LW-1:0] CAP = LW'(1) << PHASE_COUNT_BITS;

    // Configuration
    logic [15:0] phase_ticks_reg;

    // Sequencer state
    i2c_seq_pkg::seq_state_t    state_reg, state_next;
    logic [PHASE_COUNT_BITS-1:0] count_reg, count_next;
    logic [3:0]                  bit_reg, bit_next;
    logic [7:0]                  shift_reg, shift_next;
    i2c_seq_pkg::byte_sel_t     byte_reg, byte_next;
    logic                        nack_reg, nack_next;
    i2c_seq_pkg::req_kind_t     kind_reg, kind_next;
    logic [6:0]                  dev_reg, dev_next;
    logic [7:0]                  rega_reg, rega_next;
    logic [7:0]                  data_reg, data_next;

    // Output buffering
    i2c_seq_pkg::result_t main_reg, skid_reg, res_now;
    logic                  main_v_reg, skid_v_reg;

    logic accept, pop;
    logic is_idle, start;
    i2c_seq_pkg::req_kind_t req_k;

    // Effective values for this tick (latched on a starting request)
    i2c_seq_pkg::seq_state_t st;
    logic [PHASE_COUNT_BITS-1:0] cnt;
    logic [3:0]  bit_e;
    logic [7:0]  shift_e;
    i2c_seq_pkg::byte_sel_t byte_e;
    logic        nack_e;
    i2c_seq_pkg::req_kind_t kind_e;
    logic [6:0]  dev_e;
    logic [7:0]  rega_e, data_e;

    logic [LW-1:0] len_raw, len, cnt_inc;
    logic          last;
    logic [7:0]    shift_smp;
    logic          nack_smp;
    logic [3:0]    bit_inc;
    logic          done;

    assign accept = req_ch.valid && req_ch.ready;
    assign pop    = main_v_reg && res_ch.ready;
    assign req_ch.ready = !skid_v_reg;

    assign req_k   = i2c_seq_pkg::req_kind_t'(req_ch.req_type);
    assign is_idle = (state_reg == i2c_seq_pkg::ST_IDLE);
    assign start   = is_idle && (req_k != i2c_seq_pkg::REQ_NONE);

    always_comb
    begin
        st      = start ? i2c_seq_pkg::ST_PREP : state_reg;
        cnt     = start ? '0 : count_reg;
        bit_e   = start ? 4'd0 : bit_reg;
        shift_e = start ? 8'd0 : shift_reg;
        byte_e  = start ? i2c_seq_pkg::BYTE_ADDR : byte_reg;
        nack_e  = start ? 1'b0 : nack_reg;
        kind_e  = start ? req_k : kind_reg;
        dev_e   = start ? req_ch.dev_addr : dev_reg;
        rega_e  = start ? req_ch.reg_addr : rega_reg;
        data_e  = start ? req_ch.wr_data  : data_reg;
    end

    // Phase length: zero acts as one, saturates at the counter range
    always_comb
    begin
        len_raw = (phase_ticks_reg == 16'd0) ? LW'(1) : LW'(phase_ticks_reg);
        len     = (len_raw > CAP) ? CAP : len_raw;
        cnt_inc = LW'(cnt) + LW'(1);
        last    = (cnt_inc >= len);
    end

    // Sampling: read bits on first high tick, ACK on last high tick
    always_comb
    begin
        shift_smp = shift_e;
        if (st == i2c_seq_pkg::ST_RHI && cnt == '0)
            shift_smp = {shift_e[6:0], req_ch.sda_in};
        nack_smp = nack_e;
        if (st == i2c_seq_pkg::ST_A2 && last)
            nack_smp = nack_e | req_ch.sda_in;
        bit_inc = bit_e + 4'd1;
    end

    // Next-state logic
    always_comb
    begin
        state_next = st;
        count_next = last ? '0 : cnt_inc[PHASE_COUNT_BITS-1:0];
        bit_next   = bit_e;
        shift_next = shift_smp;
        byte_next  = byte_e;
        nack_next  = nack_smp;
        kind_next  = kind_e;
        dev_next   = dev_e;
        rega_next  = rega_e;
        data_next  = data_e;
        done       = 1'b0;
        if (last)
        begin
            case (st)
                i2c_seq_pkg::ST_PREP: state_next = i2c_seq_pkg::ST_S1;
                i2c_seq_pkg::ST_S1:   state_next = i2c_seq_pkg::ST_S2;
                i2c_seq_pkg::ST_S2:   state_next = i2c_seq_pkg::ST_S3;
                i2c_seq_pkg::ST_S3:
                begin
                    shift_next = {dev_e, (byte_e == i2c_seq_pkg::BYTE_THIRD)};
                    bit_next   = 4'd0;
                    state_next = i2c_seq_pkg::ST_WLO;
                end
                i2c_seq_pkg::ST_WLO:  state_next = i2c_seq_pkg::ST_WHI;
                i2c_seq_pkg::ST_WHI:  state_next = i2c_seq_pkg::ST_WLO2;
                i2c_seq_pkg::ST_WLO2:
                begin
                    shift_next = {shift_smp[6:0], 1'b0};
                    bit_next   = bit_inc;
                    state_next = (bit_inc >= i2c_seq_pkg::BITS_PER_BYTE) ?
                                 i2c_seq_pkg::ST_A1 : i2c_seq_pkg::ST_WLO;
                end
                i2c_seq_pkg::ST_A1:   state_next = i2c_seq_pkg::ST_A2;
                i2c_seq_pkg::ST_A2:   state_next = i2c_seq_pkg::ST_A3;
                i2c_seq_pkg::ST_A3:
                begin
                    case (kind_e)
                        i2c_seq_pkg::REQ_READ:
                        begin
                            if (nack_smp)
                            begin
                                // abort: report all ones
                                shift_next = i2c_seq_pkg::ABORT_DATA;
                                state_next = i2c_seq_pkg::ST_P1;
                            end
                            else if (byte_e == i2c_seq_pkg::BYTE_ADDR)
                            begin
                                byte_next  = i2c_seq_pkg::BYTE_REG;
                                shift_next = rega_e;
                                bit_next   = 4'd0;
                                state_next = i2c_seq_pkg::ST_WLO;
                            end
                            else if (byte_e == i2c_seq_pkg::BYTE_REG)
                            begin
                                // repeated START, then address+R
                                byte_next  = i2c_seq_pkg::BYTE_THIRD;
                                state_next = i2c_seq_pkg::ST_S1;
                            end
                            else
                            begin
                                shift_next = 8'd0;
                                bit_next   = 4'd0;
                                state_next = i2c_seq_pkg::ST_RLO;
                            end
                        end
                        i2c_seq_pkg::REQ_REG_WRITE:
                        begin
                            if (byte_e == i2c_seq_pkg::BYTE_ADDR)
                            begin
                                byte_next  = i2c_seq_pkg::BYTE_REG;
                                shift_next = rega_e;
                                bit_next   = 4'd0;
                                state_next = i2c_seq_pkg::ST_WLO;
                            end
                            else if (byte_e == i2c_seq_pkg::BYTE_REG)
                            begin
                                byte_next  = i2c_seq_pkg::BYTE_THIRD;
                                shift_next = data_e;
                                bit_next   = 4'd0;
                                state_next = i2c_seq_pkg::ST_WLO;
                            end
                            else
                                state_next = i2c_seq_pkg::ST_P1;
                        end
                        default:
                        begin
                            if (byte_e == i2c_seq_pkg::BYTE_ADDR)
                            begin
                                byte_next  = i2c_seq_pkg::BYTE_REG;
                                shift_next = data_e;
                                bit_next   = 4'd0;
                                state_next = i2c_seq_pkg::ST_WLO;
                            end
                            else
                                state_next = i2c_seq_pkg::ST_P1;
                        end
                    endcase
                end
                i2c_seq_pkg::ST_RLO:  state_next = i2c_seq_pkg::ST_RHI;
                i2c_seq_pkg::ST_RHI:
                begin
                    bit_next   = bit_inc;
                    state_next = (bit_inc >= i2c_seq_pkg::BITS_PER_BYTE) ?
                                 i2c_seq_pkg::ST_N1 : i2c_seq_pkg::ST_RLO;
                end
                i2c_seq_pkg::ST_N1:   state_next = i2c_seq_pkg::ST_N2;
                i2c_seq_pkg::ST_N2:   state_next = i2c_seq_pkg::ST_N3;
                i2c_seq_pkg::ST_N3:   state_next = i2c_seq_pkg::ST_P1;
                i2c_seq_pkg::ST_P1:   state_next = i2c_seq_pkg::ST_P2;
                i2c_seq_pkg::ST_P2:   state_next = i2c_seq_pkg::ST_P3;
                i2c_seq_pkg::ST_P3:
                begin
                    state_next = i2c_seq_pkg::ST_IDLE;
                    done       = 1'b1;
                end
                default: state_next = i2c_seq_pkg::ST_IDLE;
            endcase
        end
    end

    // Result word for this tick
    always_comb
    begin
        res_now = '0;
        if (!is_idle || start)
        begin
            res_now.scl_pull_low = i2c_seq_pkg::scl_of(st);
            if (st == i2c_seq_pkg::ST_WLO || st == i2c_seq_pkg::ST_WHI ||
                st == i2c_seq_pkg::ST_WLO2)
                res_now.sda_pull_low = ~shift_e[7];
            else
                res_now.sda_pull_low = i2c_seq_pkg::sda_of(st);
            res_now.busy_res = 1'b1;
            res_now.rejected = !is_idle && (req_k != i2c_seq_pkg::REQ_NONE);
            if (done)
            begin
                res_now.done_res  = 1'b1;
                res_now.read_data = (kind_e == i2c_seq_pkg::REQ_READ) ? shift_next : 8'd0;
                res_now.nack      = nack_smp;
            end
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_ticks_reg <= i2c_seq_pkg::PHASE_TICKS_RESET;
        else if (cfg_we)
            phase_ticks_reg <= cfg_wdata;
    end

    // Sequencer state; idle ticks with no request leave it untouched
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= i2c_seq_pkg::ST_IDLE;
            count_reg <= '0;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            byte_reg  <= i2c_seq_pkg::BYTE_ADDR;
            nack_reg  <= 1'b0;
            kind_reg  <= i2c_seq_pkg::REQ_NONE;
            dev_reg   <= 7'd0;
            rega_reg  <= 8'd0;
            data_reg  <= 8'd0;
        end
        else if (accept && (!is_idle || start))
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            byte_reg  <= byte_next;
            nack_reg  <= nack_next;
            kind_reg  <= kind_next;
            dev_reg   <= dev_next;
            rega_reg  <= rega_next;
            data_reg  <= data_next;
        end
    end

    // Output register plus skid word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!main_v_reg || pop)
        begin
            if (skid_v_reg)
            begin
                main_v_reg <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
                main_v_reg <= accept;
        end
        else if (accept)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!main_v_reg || pop)
        begin
            if (skid_v_reg)
                main_reg <= skid_reg;
            else if (accept)
                main_reg <= res_now;
        end
        else if (accept)
            skid_reg <= res_now;
    end

    assign res_ch.valid        = main_v_reg;
    assign res_ch.scl_pull_low = main_reg.scl_pull_low;
    assign res_ch.sda_pull_low = main_reg.sda_pull_low;
    assign res_ch.busy_res     = main_reg.busy_res;
    assign res_ch.done_res     = main_reg.done_res;
    assign res_ch.read_data    = main_reg.read_data;
    assign res_ch.nack         = main_reg.nack;
    assign res_ch.rejected     = main_reg.rejected;

endmodule

[tb/i2c_master_transaction_sequencer_top_test.sv]
module i2c_master_transaction_sequencer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Watchdog budget in clock cycles. A correct run stays within it
    // even with both sides stalling on every word.
    localparam int unsigned CYCLE_LIMIT   = 500_000;
    localparam int unsigned TICKS_PER_SET = 270;

    // ------------------------------------------------------------------
    // Bus sequencer model plus expected-word store. Every accepted request
    // word is one tick and yields exactly one result word.
    // ------------------------------------------------------------------
    class bus_tick_scoreboard;
        logic [15:0]             phase_ticks;
        i2c_seq_pkg::seq_state_t st;
        logic [15:0]             phase_cnt;
        logic [3:0]              bit_idx;
        logic [7:0]              shreg;
        i2c_seq_pkg::byte_sel_t  byte_sel;
        logic                    nack_seen;
        i2c_seq_pkg::req_kind_t  kind;
        logic [6:0]              dev_q;
        logic [7:0]              reg_q;
        logic [7:0]              data_q;
        i2c_seq_pkg::result_t    expected_ticks[$];
        int unsigned             fail_count;

        function new();
            phase_ticks = i2c_seq_pkg::PHASE_TICKS_RESET;
            st          = i2c_seq_pkg::ST_IDLE;
            phase_cnt   = '0;
            bit_idx     = '0;
            shreg       = '0;
            byte_sel    = i2c_seq_pkg::BYTE_ADDR;
            nack_seen   = 1'b0;
            kind        = i2c_seq_pkg::REQ_NONE;
            dev_q       = '0;
            reg_q       = '0;
            data_q      = '0;
            fail_count  = 0;
        endfunction

        function void load_shift(input logic [7:0] b);
            shreg   = b;
            bit_idx = '0;
            st      = i2c_seq_pkg::ST_WLO;
        endfunction

        // One tick of the sequencer; returns the word it should put out.
        function i2c_seq_pkg::result_t predict_tick(input i2c_seq_pkg::req_kind_t req,
                                                    input logic [6:0] dev,
                                                    input logic [7:0] rg,
                                                    input logic [7:0] dat,
                                                    input logic sda);
            i2c_seq_pkg::result_t r;
            int unsigned          plen;
            bit                   last;
            bit                   fin;
            r = '0;
            if (st == i2c_seq_pkg::ST_IDLE)
            begin
                if (req == i2c_seq_pkg::REQ_NONE)
                    return r;
                kind      = req;
                dev_q     = dev;
                reg_q     = rg;
                data_q    = dat;
                nack_seen = 1'b0;
                bit_idx   = '0;
                byte_sel  = i2c_seq_pkg::BYTE_ADDR;
                shreg     = '0;
                phase_cnt = '0;
                st        = i2c_seq_pkg::ST_PREP;
            end
            else if (req != i2c_seq_pkg::REQ_NONE)
            begin
                r.rejected = 1'b1;
            end

            // pins follow the phase; write bits put the MSB on SDA
            r.scl_pull_low = st inside {i2c_seq_pkg::ST_S3, i2c_seq_pkg::ST_WLO,
                                        i2c_seq_pkg::ST_WLO2, i2c_seq_pkg::ST_A1,
                                        i2c_seq_pkg::ST_A3, i2c_seq_pkg::ST_RLO,
                                        i2c_seq_pkg::ST_N1, i2c_seq_pkg::ST_N3,
                                        i2c_seq_pkg::ST_P1};
            if (st inside {i2c_seq_pkg::ST_WLO, i2c_seq_pkg::ST_WHI, i2c_seq_pkg::ST_WLO2})
                r.sda_pull_low = !shreg[7];
            else
                r.sda_pull_low = st inside {i2c_seq_pkg::ST_S2, i2c_seq_pkg::ST_S3,
                                            i2c_seq_pkg::ST_P1, i2c_seq_pkg::ST_P2};
            r.busy_res = 1'b1;

            // zero length acts as one; a shortened phase ends at once
            plen = (phase_ticks == 0) ? 1 : phase_ticks;
            last = (int'(phase_cnt) + 1 >= plen);
            if (st == i2c_seq_pkg::ST_RHI && phase_cnt == 0)
                shreg = {shreg[6:0], sda};
            if (st == i2c_seq_pkg::ST_A2 && last)
                nack_seen = nack_seen | sda;

            fin = 1'b0;
            if (!last)
            begin
                phase_cnt = phase_cnt + 1'b1;
            end
            else
            begin
                phase_cnt = '0;
                case (st)
                    i2c_seq_pkg::ST_PREP: st = i2c_seq_pkg::ST_S1;
                    i2c_seq_pkg::ST_S1:   st = i2c_seq_pkg::ST_S2;
                    i2c_seq_pkg::ST_S2:   st = i2c_seq_pkg::ST_S3;
                    i2c_seq_pkg::ST_S3:
                        load_shift({dev_q, byte_sel == i2c_seq_pkg::BYTE_THIRD});
                    i2c_seq_pkg::ST_WLO:  st = i2c_seq_pkg::ST_WHI;
                    i2c_seq_pkg::ST_WHI:  st = i2c_seq_pkg::ST_WLO2;
                    i2c_seq_pkg::ST_WLO2:
                    begin
                        shreg   = shreg << 1;
                        bit_idx = bit_idx + 1'b1;
                        st      = (bit_idx >= i2c_seq_pkg::BITS_PER_BYTE) ?
                                  i2c_seq_pkg::ST_A1 : i2c_seq_pkg::ST_WLO;
                    end
                    i2c_seq_pkg::ST_A1:   st = i2c_seq_pkg::ST_A2;
                    i2c_seq_pkg::ST_A2:   st = i2c_seq_pkg::ST_A3;
                    i2c_seq_pkg::ST_A3:
                    begin
                        case (kind)
                            i2c_seq_pkg::REQ_READ:
                            begin
                                if (nack_seen)
                                begin
                                    shreg = i2c_seq_pkg::ABORT_DATA;
                                    st    = i2c_seq_pkg::ST_P1;
                                end
                                else if (byte_sel == i2c_seq_pkg::BYTE_ADDR)
                                begin
                                    byte_sel = i2c_seq_pkg::BYTE_REG;
                                    load_shift(reg_q);
                                end
                                else if (byte_sel == i2c_seq_pkg::BYTE_REG)
                                begin
                                    byte_sel = i2c_seq_pkg::BYTE_THIRD;
                                    st       = i2c_seq_pkg::ST_S1;
                                end
                                else
                                begin
                                    shreg   = '0;
                                    bit_idx = '0;
                                    st      = i2c_seq_pkg::ST_RLO;
                                end
                            end
                            i2c_seq_pkg::REQ_REG_WRITE:
                            begin
                                if (byte_sel == i2c_seq_pkg::BYTE_ADDR)
                                begin
                                    byte_sel = i2c_seq_pkg::BYTE_REG;
                                    load_shift(reg_q);
                                end
                                else if (byte_sel == i2c_seq_pkg::BYTE_REG)
                                begin
                                    byte_sel = i2c_seq_pkg::BYTE_THIRD;
                                    load_shift(data_q);
                                end
                                else
                                begin
                                    st = i2c_seq_pkg::ST_P1;
                                end
                            end
                            default:
                            begin
                                if (byte_sel == i2c_seq_pkg::BYTE_ADDR)
                                begin
                                    byte_sel = i2c_seq_pkg::BYTE_REG;
                                    load_shift(data_q);
                                end
                                else
                                begin
                                    st = i2c_seq_pkg::ST_P1;
                                end
                            end
                        endcase
                    end
                    i2c_seq_pkg::ST_RLO:  st = i2c_seq_pkg::ST_RHI;
                    i2c_seq_pkg::ST_RHI:
                    begin
                        bit_idx = bit_idx + 1'b1;
                        st      = (bit_idx >= i2c_seq_pkg::BITS_PER_BYTE) ?
                                  i2c_seq_pkg::ST_N1 : i2c_seq_pkg::ST_RLO;
                    end
                    i2c_seq_pkg::ST_N1:   st = i2c_seq_pkg::ST_N2;
                    i2c_seq_pkg::ST_N2:   st = i2c_seq_pkg::ST_N3;
                    i2c_seq_pkg::ST_N3:   st = i2c_seq_pkg::ST_P1;
                    i2c_seq_pkg::ST_P1:   st = i2c_seq_pkg::ST_P2;
                    i2c_seq_pkg::ST_P2:   st = i2c_seq_pkg::ST_P3;
                    i2c_seq_pkg::ST_P3:
                    begin
                        st  = i2c_seq_pkg::ST_IDLE;
                        fin = 1'b1;
                    end
                    default: st = i2c_seq_pkg::ST_IDLE;
                endcase
            end

            if (fin)
            begin
                r.done_res  = 1'b1;
                r.read_data = (kind == i2c_seq_pkg::REQ_READ) ? shreg : 8'h00;
                r.nack      = nack_seen;
            end
            return r;
        endfunction

        function void note_tick(input i2c_seq_pkg::req_kind_t req, input logic [6:0] dev,
                                input logic [7:0] rg, input logic [7:0] dat,
                                input logic sda);
            expected_ticks.push_back(predict_tick(req, dev, rg, dat, sda));
        endfunction

        function void compare_field(input string name, input logic [7:0] exp_v,
                                    input logic [7:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s: expected %0h, got %0h", name, exp_v, act_v);
                fail_count++;
            end
        endfunction

        function void check_tick(input i2c_seq_pkg::result_t got);
            i2c_seq_pkg::result_t e;
            if (expected_ticks.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
                return;
            end
            e = expected_ticks.pop_front();
            compare_field("scl_pull_low", 8'(e.scl_pull_low), 8'(got.scl_pull_low));
            compare_field("sda_pull_low", 8'(e.sda_pull_low), 8'(got.sda_pull_low));
            compare_field("busy_res", 8'(e.busy_res), 8'(got.busy_res));
            compare_field("done_res", 8'(e.done_res), 8'(got.done_res));
            compare_field("read_data", e.read_data, got.read_data);
            compare_field("nack", 8'(e.nack), 8'(got.nack));
            compare_field("rejected", 8'(e.rejected), 8'(got.rejected));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    i2c_seq_in_if  req_if();
    i2c_seq_out_if res_if();

    bus_tick_scoreboard sb = new();

    // Idle pattern state per side: runs of words either back to back or
    // with random gaps, so both dense stretches and stalls show up.
    int unsigned snd_left = 0;
    bit          snd_idle = 1'b0;
    int unsigned rcv_left = 0;
    bit          rcv_idle = 1'b0;

    i2c_master_transaction_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_ch    (req_if),
        .res_ch    (res_if)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Sample both channels at the rising edge; an input word is fed to the
    // model as it is taken, a result word is checked as it leaves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
                sb.note_tick(i2c_seq_pkg::req_kind_t'(req_if.req_type), req_if.dev_addr,
                             req_if.reg_addr, req_if.wr_data, req_if.sda_in);
            if (res_if.valid && res_if.ready)
                sb.check_tick({res_if.scl_pull_low, res_if.sda_pull_low,
                               res_if.busy_res, res_if.done_res, res_if.read_data,
                               res_if.nack, res_if.rejected});
        end
    end

    // Watchdog
    initial
    begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("i2c_master_transaction_sequencer_top regression: fail");
        $finish;
    end

    function automatic int unsigned next_gap(inout int unsigned left, inout bit idling);
        if (left == 0)
        begin
            left   = $urandom_range(1, 40);
            idling = ($urandom_range(0, 2) != 0);
        end
        left--;
        return idling ? $urandom_range(0, 18) : 0;
    endfunction

    // Field values lean toward the ends of their range.
    function automatic logic [7:0] pick_field(input logic [7:0] max_v);
        logic [7:0] v;
        case ($urandom_range(0, 9))
            0:       v = 8'h00;
            1:       v = max_v;
            default: v = 8'($urandom_range(0, max_v));
        endcase
        return v;
    endfunction

    // Result side: ready is held low for a random gap before a word in some runs.
    initial
    begin : result_sink
        int unsigned gap;
        res_if.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            gap = next_gap(rcv_left, rcv_idle);
            if (gap != 0)
            begin
                res_if.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_if.ready = 1'b1;
            @(posedge clk);
            while (!res_if.valid) @(posedge clk);
            @(negedge clk);
        end
    end

    // Drive one tick word; entered and left at a falling edge. valid stays
    // high between back-to-back words.
    task automatic send_tick(input i2c_seq_pkg::req_kind_t req, input logic [6:0] dev,
                             input logic [7:0] rg, input logic [7:0] dat,
                             input logic sda);
        int unsigned gap;
        gap = next_gap(snd_left, snd_idle);
        if (gap != 0)
        begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.req_type = req;
        req_if.dev_addr = dev;
        req_if.reg_addr = rg;
        req_if.wr_data  = dat;
        req_if.sda_in   = sda;
        req_if.valid    = 1'b1;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Random tick shaped by where the model thinks the bus is: new
    // requests mostly when idle, few (rejected) ones when busy, and
    // mostly ACKs while an acknowledge is being sampled.
    task automatic send_random_tick;
        i2c_seq_pkg::req_kind_t req;
        logic                   sda;
        logic [7:0]             dev8;
        if (sb.st == i2c_seq_pkg::ST_IDLE)
            req = ($urandom_range(0, 9) < 8) ?
                  i2c_seq_pkg::req_kind_t'($urandom_range(1, 3)) : i2c_seq_pkg::REQ_NONE;
        else
            req = ($urandom_range(0, 99) < 8) ?
                  i2c_seq_pkg::req_kind_t'($urandom_range(1, 3)) : i2c_seq_pkg::REQ_NONE;
        if (sb.st inside {i2c_seq_pkg::ST_A1, i2c_seq_pkg::ST_A2, i2c_seq_pkg::ST_A3})
            sda = ($urandom_range(0, 99) < 12);
        else
            sda = 1'($urandom_range(0, 1));
        dev8 = pick_field(8'd127);
        send_tick(req, dev8[6:0], pick_field(8'hff), pick_field(8'hff), sda);
    endtask

    // Stop sending and wait until every expected word is back.
    task automatic drain_results;
        req_if.valid = 1'b0;
        while (sb.expected_ticks.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    // Register write with the channel quiet; often lands mid-transaction,
    // which exercises a phase length change on the fly.
    task automatic set_phase_ticks(input logic [15:0] v);
        drain_results();
        cfg_we         = 1'b1;
        cfg_wdata      = v;
        sb.phase_ticks = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin : stimulus
        logic [15:0] phase_set[6];
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        req_if.valid    = 1'b0;
        req_if.req_type = i2c_seq_pkg::REQ_NONE;
        req_if.dev_addr = '0;
        req_if.reg_addr = '0;
        req_if.wr_data  = '0;
        req_if.sda_in   = 1'b0;
        phase_set       = '{16'd1, 16'd2, 16'd0, 16'd1, 16'd3, 16'd1};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: idle ticks with no request give all-zero words.
        send_tick(i2c_seq_pkg::REQ_NONE, 7'h7f, 8'hff, 8'hff, 1'b1);
        send_tick(i2c_seq_pkg::REQ_NONE, 7'h00, 8'h00, 8'h00, 1'b0);
        // Read with all-ones fields at the reset phase length.
        send_tick(i2c_seq_pkg::REQ_READ, 7'h7f, 8'hff, 8'hff, 1'b1);
        // Every request kind while busy is rejected.
        send_tick(i2c_seq_pkg::REQ_REG_WRITE, 7'h00, 8'h00, 8'h00, 1'b0);
        send_tick(i2c_seq_pkg::REQ_BYTE_WRITE, 7'h00, 8'h00, 8'h00, 1'b1);
        send_tick(i2c_seq_pkg::REQ_READ, 7'h7f, 8'h00, 8'hff, 1'b0);
        // Longest phase, then zero length mid-phase: the phase ends at once.
        set_phase_ticks(16'hffff);
        send_tick(i2c_seq_pkg::REQ_NONE, 7'h55, 8'haa, 8'h55, 1'b1);
        send_tick(i2c_seq_pkg::REQ_NONE, 7'h2a, 8'h55, 8'haa, 1'b0);
        set_phase_ticks(16'h0000);
        repeat (8) send_tick(i2c_seq_pkg::REQ_NONE, 7'h00, 8'h00, 8'h00, 1'b0);

        // Random sets, each at its own phase length; every switch happens
        // with the pipeline drained but the bus usually mid-transfer.
        foreach (phase_set[i])
        begin
            set_phase_ticks(phase_set[i]);
            repeat (TICKS_PER_SET)
            begin
                if ($urandom_range(0, 199) == 0)
                    drain_results();
                send_random_tick();
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (sb.fail_count == 0 && sb.expected_ticks.size() == 0)
            $display("i2c_master_transaction_sequencer_top regression: pass");
        else
            $display("i2c_master_transaction_sequencer_top regression: fail");
        $finish;
    end

endmodule
